// ===== rtl/nearest_downscale_rgb565_gray_defines.svh =====
// ----------------------------------------------------------------------------
// nearest_downscale_rgb565_gray assertion macros
// shared property forms for the downscaler checks, clocked on i_clk and
// disabled while reset is held
// ----------------------------------------------------------------------------
`ifndef NEAREST_DOWNSCALE_RGB565_GRAY_DEFINES_SVH
`define NEAREST_DOWNSCALE_RGB565_GRAY_DEFINES_SVH

// same-cycle implication
`define NDG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NDG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ndg_pkg.sv =====
// ----------------------------------------------------------------------------
// ndg_pkg
// types and fixed constants of the nearest-neighbour rgb565 to gray downscaler
// ----------------------------------------------------------------------------
package ndg_pkg;

    localparam int PIXEL_W   = 16;
    localparam int GRAY_W    = 8;
    localparam int COORD_W   = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // luma weights, sum of weighted 8-bit components fits in 15 bits
    localparam int SUM_W = 15;
    localparam logic [SUM_W-1:0] W_RED   = SUM_W'(30);
    localparam logic [SUM_W-1:0] W_GREEN = SUM_W'(59);
    localparam logic [SUM_W-1:0] W_BLUE  = SUM_W'(11);

    // divide by 100 as multiply by ceil(2^19/100) and shift
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int PROD_W = SUM_W + RECIP_W;

    // queue between selection and conversion
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    // kept source pixel with its output position
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               eof;
    } t_kept;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic s1_valid;
        logic pop;
    } t_back_stat;

endpackage

// ===== rtl/ndg_front.sv =====
// ----------------------------------------------------------------------------
// ndg_front
// raster position tracking and nearest-neighbour selection by accumulators
// ----------------------------------------------------------------------------
module ndg_front
    import ndg_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [$clog2(MAX_DIM):0]        i_sw,
    input  logic [$clog2(MAX_DIM):0]        i_sh,
    input  logic [$clog2(MAX_DIM):0]        i_dw,
    input  logic [$clog2(MAX_DIM):0]        i_dh,
    input  logic                            i_pix_valid,
    output logic                            o_pix_ready,
    input  logic [PIXEL_W-1:0]              i_pixel,
    input  logic                            i_q_full,
    output logic                            o_push,
    output t_kept                           o_push_data
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int DIMW = CW + 1;
    localparam int ACCW = 2 * CW + 2;

    logic [CW-1:0]   r_sc, n_sc, r_sr, n_sr, r_oc, n_oc, r_or, n_or;
    logic [ACCW-1:0] r_ct, n_ct, r_cp, n_cp, r_rt, n_rt, r_rp, n_rp;
    logic            accept, col_hit, row_hit, hit, col_end, row_end;

    // no word is taken while reset is held
    assign o_pix_ready = i_rst_n && !i_q_full;
    assign accept      = i_pix_valid && o_pix_ready;

    assign row_hit = (r_rt >= r_rp) && (r_rt < r_rp + ACCW'(i_dh));
    assign col_hit = (r_ct >= r_cp) && (r_ct < r_cp + ACCW'(i_dw));
    assign hit     = row_hit && col_hit;
    assign col_end = DIMW'(r_sc) >= i_sw - DIMW'(1);
    assign row_end = DIMW'(r_sr) >= i_sh - DIMW'(1);

    assign o_push            = accept && hit;
    assign o_push_data.pixel = i_pixel;
    assign o_push_data.col   = COORD_W'(r_oc);
    assign o_push_data.row   = COORD_W'(r_or);
    assign o_push_data.eof   = (DIMW'(r_oc) == i_dw - DIMW'(1))
                             && (DIMW'(r_or) == i_dh - DIMW'(1));

    always_comb begin
        n_sc = r_sc; n_sr = r_sr; n_oc = r_oc; n_or = r_or;
        n_ct = r_ct; n_cp = r_cp; n_rt = r_rt; n_rp = r_rp;
        if (accept) begin
            if (hit) begin
                n_oc = r_oc + CW'(1);
                n_ct = r_ct + ACCW'(i_sw);
            end
            if (col_end) begin
                n_sc = '0; n_oc = '0; n_ct = '0; n_cp = '0;
                if (row_end) begin
                    n_sr = '0; n_or = '0; n_rt = '0; n_rp = '0;
                end else begin
                    if (row_hit) begin
                        n_or = r_or + CW'(1);
                        n_rt = r_rt + ACCW'(i_sh);
                    end
                    n_sr = r_sr + CW'(1);
                    n_rp = r_rp + ACCW'(i_dh);
                end
            end else begin
                n_sc = r_sc + CW'(1);
                n_cp = r_cp + ACCW'(i_dw);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= '0; r_sr <= '0; r_oc <= '0; r_or <= '0;
            r_ct <= '0; r_cp <= '0; r_rt <= '0; r_rp <= '0;
        end else begin
            r_sc <= n_sc; r_sr <= n_sr; r_oc <= n_oc; r_or <= n_or;
            r_ct <= n_ct; r_cp <= n_cp; r_rt <= n_rt; r_rp <= n_rp;
        end
    end

endmodule

// ===== rtl/ndg_queue.sv =====
// ----------------------------------------------------------------------------
// ndg_queue
// two-word queue between selection and gray conversion
// ----------------------------------------------------------------------------
module ndg_queue
    import ndg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_kept   i_push_data,
    input  logic    i_pop,
    output t_kept   o_pop_data,
    output t_q_stat o_stat
);

    t_kept               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    assign o_stat.full  = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/ndg_back.sv =====
// ----------------------------------------------------------------------------
// ndg_back
// gray conversion pipeline: weighted sum, reciprocal divide, output register
// ----------------------------------------------------------------------------
module ndg_back
    import ndg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_kept              i_q_data,
    output t_back_stat         o_stat,
    output logic               o_gray_valid,
    input  logic               i_gray_ready,
    output logic [GRAY_W-1:0]  o_gray,
    output logic [COORD_W-1:0] o_out_col,
    output logic [COORD_W-1:0] o_out_row,
    output logic               o_end_of_frame
);

    logic               r_s1_valid, r_out_valid;
    logic [SUM_W-1:0]   r_s1_sum;
    t_kept              r_s1_meta;
    logic [GRAY_W-1:0]  r_gray;
    logic [COORD_W-1:0] r_col, r_row;
    logic               r_eof;
    logic               adv, s1_en, pop;
    logic [7:0]         red8, green8, blue8;
    logic [SUM_W-1:0]   sum;
    logic [PROD_W-1:0]  prod;

    assign adv   = !r_out_valid || i_gray_ready;
    assign s1_en = !r_s1_valid || adv;
    assign pop   = !i_q_empty && s1_en;

    // 5/6/5 components widened to 8 bits
    assign red8   = {i_q_data.pixel[15:11], 3'b000};
    assign green8 = {i_q_data.pixel[10:5], 2'b00};
    assign blue8  = {i_q_data.pixel[4:0], 3'b000};
    assign sum    = SUM_W'(red8) * W_RED + SUM_W'(green8) * W_GREEN
                  + SUM_W'(blue8) * W_BLUE;

    assign prod = PROD_W'(r_s1_sum) * PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_sum  <= sum;
            r_s1_meta <= i_q_data;
        end
        if (adv) begin
            r_gray <= GRAY_W'(prod >> RECIP_SHIFT);
            r_col  <= r_s1_meta.col;
            r_row  <= r_s1_meta.row;
            r_eof  <= r_s1_meta.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= !i_q_empty;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.pop      = pop;
    assign o_gray_valid    = r_out_valid;
    assign o_gray          = r_gray;
    assign o_out_col       = r_col;
    assign o_out_row       = r_row;
    assign o_end_of_frame  = r_eof;

endmodule

// ===== rtl/nearest_downscale_rgb565_gray.sv =====
// ----------------------------------------------------------------------------
// nearest_downscale_rgb565_gray
// nearest-neighbour downscaler for rgb565 raster streams with gray output
// ----------------------------------------------------------------------------
// Takes one rgb565 source pixel per clock in raster order and keeps the pixel
// at source position (floor(oc*sw/dw), floor(or*sh/dh)) for every output
// position, giving its gray value (r*30 + g*59 + b*11)/100 with the output
// column, output row and an end-of-frame flag on the last output pixel. A new
// pixel word is taken every cycle while the two-word queue has room; the rate
// is set by the selection front, whose accumulator compare is combinational
// and whose update is registered. A kept pixel reaches the output through
// the queue memory, the weighted-sum stage register and then the output
// register, where the reciprocal divide lands. Sizes are written through
// the configuration port at indices 0..3 (source width, source height,
// destination width, destination height; reset 160, 120, 64, 64); zero counts
// as 1, source sizes are limited to MAX_DIM and destination sizes to the
// source size. New sizes apply from the first pixel word after the write; a
// change in mid-frame takes effect at once while the position counters run
// on, and targets that fall out of step give no words until the row or frame
// ends. Neither input channel takes a word while reset is held.
// ----------------------------------------------------------------------------
`include "nearest_downscale_rgb565_gray_defines.svh"

module nearest_downscale_rgb565_gray
    import ndg_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // source pixel channel
    input  logic                 i_pix_valid,
    output logic                 o_pix_ready,
    input  logic [PIXEL_W-1:0]   i_pixel,
    // gray pixel channel
    output logic                 o_gray_valid,
    input  logic                 i_gray_ready,
    output logic [GRAY_W-1:0]    o_gray,
    output logic [COORD_W-1:0]   o_out_col,
    output logic [COORD_W-1:0]   o_out_row,
    output logic                 o_end_of_frame
);

    localparam int DIMW = $clog2(MAX_DIM) + 1;

    // raw register contents as written
    logic [CFG_W-1:0] r_src_width, r_src_height, r_dst_width, r_dst_height;
    logic [CFG_W-1:0] n_src_width, n_src_height, n_dst_width, n_dst_height;
    // effective sizes after clamping
    logic [DIMW-1:0]  r_sw, r_sh, r_dw, r_dh;
    logic [DIMW-1:0]  n_sw, n_sh, n_dw, n_dh;

    logic             cfg_we;
    logic             push;
    t_kept            push_data, pop_data;
    t_q_stat          q_stat;
    t_back_stat       back_stat;

    // zero counts as one, anything above the limit counts as the limit
    function automatic logic [DIMW-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [DIMW-1:0] lim);
        logic [DIMW:0] v_ext;
        begin
            v_ext = (DIMW + 1)'(v);
            if (v == '0) begin
                clamp_dim = DIMW'(1);
            end else if (v_ext > (DIMW + 1)'(lim)) begin
                clamp_dim = lim;
            end else begin
                clamp_dim = DIMW'(v);
            end
        end
    endfunction

    // configuration port never stalls outside reset
    assign o_cfg_ready = i_rst_n;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // register contents after this edge, so a write and its clamped size land together
    always_comb begin
        n_src_width  = r_src_width;
        n_src_height = r_src_height;
        n_dst_width  = r_dst_width;
        n_dst_height = r_dst_height;
        if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:  n_src_width  = i_cfg_data;
                CFG_SRC_HEIGHT: n_src_height = i_cfg_data;
                CFG_DST_WIDTH:  n_dst_width  = i_cfg_data;
                CFG_DST_HEIGHT: n_dst_height = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= CFG_W'(160);
            r_src_height <= CFG_W'(120);
            r_dst_width  <= CFG_W'(64);
            r_dst_height <= CFG_W'(64);
        end else begin
            r_src_width  <= n_src_width;
            r_src_height <= n_src_height;
            r_dst_width  <= n_dst_width;
            r_dst_height <= n_dst_height;
        end
    end

    // clamping is registered, so the selection path sees ready-made sizes
    always_comb begin
        n_sw = clamp_dim(n_src_width, DIMW'(MAX_DIM));
        n_sh = clamp_dim(n_src_height, DIMW'(MAX_DIM));
        n_dw = clamp_dim(n_dst_width, n_sw);
        n_dh = clamp_dim(n_dst_height, n_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= clamp_dim(CFG_W'(160), DIMW'(MAX_DIM));
            r_sh <= clamp_dim(CFG_W'(120), DIMW'(MAX_DIM));
            r_dw <= clamp_dim(CFG_W'(64), clamp_dim(CFG_W'(160), DIMW'(MAX_DIM)));
            r_dh <= clamp_dim(CFG_W'(64), clamp_dim(CFG_W'(120), DIMW'(MAX_DIM)));
        end else begin
            r_sw <= n_sw;
            r_sh <= n_sh;
            r_dw <= n_dw;
            r_dh <= n_dh;
        end
    end

    // selection front: tracks raster position, flags kept pixels
    ndg_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sw        (r_sw),
        .i_sh        (r_sh),
        .i_dw        (r_dw),
        .i_dh        (r_dh),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pixel     (i_pixel),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decouples the front from output back-pressure
    ndg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (back_stat.pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    // conversion back end with output register
    ndg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_stat.empty),
        .i_q_data       (pop_data),
        .o_stat         (back_stat),
        .o_gray_valid   (o_gray_valid),
        .i_gray_ready   (i_gray_ready),
        .o_gray         (o_gray),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_end_of_frame (o_end_of_frame)
    );

    // a kept pixel never lands on a full queue
    `NDG_ASSERT_SAME(a_push_not_full, push, !q_stat.full, "push into full queue")
    // the back end only draws words that are there
    `NDG_ASSERT_SAME(a_pop_not_empty, back_stat.pop, !q_stat.empty, "pop from empty queue")
    // a converted word moves into an empty output register at once
    `NDG_ASSERT_NEXT(a_s1_drains, back_stat.s1_valid && !o_gray_valid, o_gray_valid,
                     "stage one word not passed to output")

endmodule

// ===== test/nearest_downscale_rgb565_gray_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_downscale_rgb565_gray_tb
// self-checking bench for the rgb565 to gray nearest-neighbour downscaler:
// pixel words stream in under random gaps and back-pressure, a scoreboard
// predicts every kept gray word and its coordinates and checks each word
// taken from the output in order
// ----------------------------------------------------------------------------
module nearest_downscale_rgb565_gray_tb;
    import ndg_pkg::*;

    localparam int MAX_SIZE     = 2048;
    localparam int SETTLE       = 8;       // covers the queue and both pipe registers with margin
    localparam int HOLD_CYCLES  = 80;      // long output stall to fill the queue
    localparam int IDLE_PERCENT = 21;
    localparam int RANDOM_ITEMS = 300;
    localparam int LIMIT        = 500000;

    // one gray word as it leaves the block
    typedef struct packed {
        logic [GRAY_W-1:0]  gray;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               eof;
    } gray_word_t;

    // ------------------------------------------------------------------------
    // scoreboard: keeps its own copy of the sizes and the frame counters,
    // predicts the kept words and compares them in arrival order
    // ------------------------------------------------------------------------
    class gray_scoreboard;
        logic [CFG_W-1:0] src_w = 12'd160;
        logic [CFG_W-1:0] src_h = 12'd120;
        logic [CFG_W-1:0] dst_w = 12'd64;
        logic [CFG_W-1:0] dst_h = 12'd64;

        // position counters and the two pairs of running accumulators
        int unsigned scol, srow, ocol, orow;
        int unsigned col_tgt, col_pos, row_tgt, row_pos;

        gray_word_t  expected[$];
        int unsigned n_errors, n_pixels, n_words, n_frames;

        function int unsigned effective_size(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function logic [GRAY_W-1:0] luma(logic [PIXEL_W-1:0] p);
            int unsigned r, g, b;
            // widen 5/6/5 components to 8 bits, weights 30/59/11 over 100
            r = {p[15:11], 3'b000};
            g = {p[10:5], 2'b00};
            b = {p[4:0], 3'b000};
            return GRAY_W'((r * 30 + g * 59 + b * 11) / 100);
        endfunction

        function void clear_frame();
            scol = 0; srow = 0; ocol = 0; orow = 0;
            col_tgt = 0; col_pos = 0; row_tgt = 0; row_pos = 0;
        endfunction

        function void write_size(t_cfg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_SRC_WIDTH:  src_w = v;
                CFG_SRC_HEIGHT: src_h = v;
                CFG_DST_WIDTH:  dst_w = v;
                CFG_DST_HEIGHT: dst_h = v;
                default: ;
            endcase
        endfunction

        // source pixels still to come before the counters wrap to a new frame
        function int unsigned pixels_to_frame_end();
            int unsigned sw, sh, rest;
            sw = effective_size(src_w, MAX_SIZE);
            sh = effective_size(src_h, MAX_SIZE);
            rest = (scol >= sw - 1) ? 1 : sw - scol;
            if (srow < sh - 1)
                rest += (sh - 1 - srow) * sw;
            return rest;
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

        // one accepted source pixel: maybe one gray word, then the counters move on
        function void take_pixel(logic [PIXEL_W-1:0] p);
            int unsigned sw, sh, dw, dh;
            bit          row_hit, col_hit;
            gray_word_t  w;
            sw = effective_size(src_w, MAX_SIZE);
            sh = effective_size(src_h, MAX_SIZE);
            dw = effective_size(dst_w, sw);
            dh = effective_size(dst_h, sh);
            n_pixels++;

            row_hit = row_tgt >= row_pos && row_tgt < row_pos + dh;
            col_hit = col_tgt >= col_pos && col_tgt < col_pos + dw;
            if (row_hit && col_hit) begin
                w.gray = luma(p);
                w.col  = COORD_W'(ocol);
                w.row  = COORD_W'(orow);
                w.eof  = (ocol == dw - 1) && (orow == dh - 1);
                expected.push_back(w);
                ocol++;
                col_tgt += sw;
            end

            if (scol >= sw - 1) begin
                scol = 0; ocol = 0; col_tgt = 0; col_pos = 0;
                if (srow >= sh - 1) begin
                    clear_frame();
                    n_frames++;
                end else begin
                    if (row_hit) begin
                        orow++;
                        row_tgt += sh;
                    end
                    srow++;
                    row_pos += dh;
                end
            end else begin
                scol++;
                col_pos += dw;
            end
        endfunction

        task report(string msg);
            n_errors++;
            if (n_errors <= 100)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_word(gray_word_t got);
            gray_word_t want;
            n_words++;
            if (expected.size() == 0) begin
                report($sformatf("gray word with none expected (gray %0d col %0d row %0d)",
                                 got.gray, got.col, got.row));
            end else begin
                want = expected.pop_front();
                if (got.gray !== want.gray)
                    report($sformatf("gray %0d, expected %0d", got.gray, want.gray));
                if (got.col !== want.col)
                    report($sformatf("out_col %0d, expected %0d", got.col, want.col));
                if (got.row !== want.row)
                    report($sformatf("out_row %0d, expected %0d", got.row, want.row));
                if (got.eof !== want.eof)
                    report($sformatf("end_of_frame %0b, expected %0b at col %0d row %0d",
                                     got.eof, want.eof, want.col, want.row));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_pix_valid    = 1'b0;
    logic [PIXEL_W-1:0]   i_pixel        = '0;
    logic                 i_gray_ready   = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_pix_ready;
    logic                 o_gray_valid;
    logic [GRAY_W-1:0]    o_gray;
    logic [COORD_W-1:0]   o_out_col;
    logic [COORD_W-1:0]   o_out_row;
    logic                 o_end_of_frame;

    // stimulus controls, set with nonblocking writes so readers see them next edge
    logic steady       = 1'b0;   // no idling on either side
    logic hold_request = 1'b0;   // ask the receiver for one long stall

    gray_scoreboard     sb = new();
    logic [PIXEL_W-1:0] pattern[$];  // fixed words sent ahead of random ones
    int unsigned        cycle_count;
    int unsigned        stalled_cycles;
    int unsigned        random_sent;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    nearest_downscale_rgb565_gray dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pix_valid    (i_pix_valid),
        .o_pix_ready    (o_pix_ready),
        .i_pixel        (i_pixel),
        .o_gray_valid   (o_gray_valid),
        .i_gray_ready   (i_gray_ready),
        .o_gray         (o_gray),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_end_of_frame (o_end_of_frame)
    );

    // ------------------------------------------------------------------------
    // monitor: handshakes are sampled at the edge, before any update lands;
    // the output is checked first so a stray word cannot match a fresh pixel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_gray_valid && i_gray_ready)
                sb.check_word({o_gray, o_out_col, o_out_row, o_end_of_frame});
            if (i_cfg_valid && o_cfg_ready)
                sb.write_size(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_pix_valid && o_pix_ready)
                sb.take_pixel(i_pixel);
            if (i_pix_valid && !o_pix_ready)
                stalled_cycles++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", LIMIT, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random idling, one counted long stall on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_gray_ready <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(posedge i_clk);
                hold_request <= 1'b0;
            end else begin
                i_gray_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    function automatic logic [PIXEL_W-1:0] random_pixel();
        // now and then a corner colour, otherwise any word
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'hF800;
            3:       return 16'h07E0;
            4:       return 16'h001F;
            default: return PIXEL_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // valid stays up from one word to the next unless a gap is drawn
    task automatic send_pixel(logic [PIXEL_W-1:0] p);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_pix_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_pixel     <= p;
        do @(posedge i_clk); while (!o_pix_ready);
    endtask

    task automatic stream(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if (pattern.size() != 0)
                send_pixel(pattern.pop_front());
            else
                send_pixel(random_pixel());
        end
        i_pix_valid <= 1'b0;
    endtask

    // every expected word back, then room for a dropped pixel still in the pipe
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // sizes are only touched with the block empty, and given time to apply
    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
        logic [CFG_W-1:0] vals[4];
        vals[0] = CFG_W'(sw);
        vals[1] = CFG_W'(sh);
        vals[2] = CFG_W'(dw);
        vals[3] = CFG_W'(dh);
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned sw, sh, dw, dh, n;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // same size in and out: every pixel kept, corner colours and mid greys
        set_sizes(4, 2, 4, 2);
        pattern = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                    16'h001F, 16'h8410, 16'h0821, 16'h7BEF};
        stream(8);

        // zero sizes count as one, so each pixel is a whole 1x1 frame
        set_sizes(0, 0, 0, 0);
        stream(2);

        // destination larger than source is cut back to the source size
        set_sizes(3, 2, 4095, 7);
        stream(6);

        // size change part way through a frame, counters run on
        set_sizes(4, 2, 2, 1);
        stream(3);
        set_sizes(4, 2, 4, 1);
        stream(sb.pixels_to_frame_end());

        // oversized source sizes clamp to the maximum, the first at the start of a frame
        set_sizes(4095, 1, 2048, 0);
        stream(64);
        set_sizes(1, 4095, 0, 1024);
        stream(64);

        // long output stall while pixels keep coming, so the input backs up
        set_sizes(16, 8, 16, 8);
        hold_request <= 1'b1;
        stream(sb.pixels_to_frame_end() + 128);

        // a frame with no idling on either side
        steady <= 1'b1;
        set_sizes(16, 8, 12, 5);
        stream(sb.pixels_to_frame_end());
        wait_drained();
        steady <= 1'b0;

        // random sizes, a few frames each, including zero and clamped settings
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            sw = ($urandom_range(11) == 0) ? 0 : $urandom_range(20, 1);
            sh = ($urandom_range(11) == 0) ? 0 : $urandom_range(12, 1);
            dw = $urandom_range(sw + 3, 0);
            dh = $urandom_range(sh + 2, 0);
            set_sizes(sw, sh, dw, dh);
            n = $urandom_range(3, 1) * sb.pixels_to_frame_end();
            stream(n);
            random_sent += n;
        end

        wait_drained();
        $display("covered %0d pixels in %0d frames, %0d gray words compared",
                 sb.n_pixels, sb.n_frames, sb.n_words);
        $display("sizes from 1x1 to 2048 wide and tall, input held off for %0d cycles",
                 stalled_cycles);
        if (sb.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ndg_pkg.sv
rtl/ndg_front.sv
rtl/ndg_queue.sv
rtl/ndg_back.sv
rtl/nearest_downscale_rgb565_gray.sv
test/nearest_downscale_rgb565_gray_tb.sv
